// ----- hdl/tlcc_pkg.sv -----
package tlcc_pkg;

    // field widths
    localparam int ID_W       = 30;
    localparam int LOCAL_W    = 6;
    localparam int TILE_W     = ID_W - LOCAL_W;
    localparam int CORNER_W   = 3;
    localparam logic [CORNER_W-1:0] LAST_CORNER = 3'd7;

    // divider: quotient bits retired per cycle and quotient steps per division
    localparam int DIV_BITS  = 3;
    localparam int DIV_STEPS = TILE_W / DIV_BITS;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // configuration port
    localparam int PDATA_W     = 32;
    localparam int PADDR_W     = 3;
    localparam int TILE_SIDE_W = 9;
    localparam logic [TILE_SIDE_W-1:0] TILE_SIDE_RESET = 9'd1;
    // register index, taken from the word address bit
    localparam logic REG_TILE_SIDE = 1'b0;

    // serpentine index -> packed {x, y, z} inside the tile
    localparam logic [LOCAL_W-1:0] SERP_POS [64] = '{
         0,  1,  5,  4, 20, 21, 17, 16,
         2,  3,  7,  6, 22, 23, 19, 18,
        10, 11, 15, 14, 30, 31, 27, 26,
         8,  9, 13, 12, 28, 29, 25, 24,
        40, 41, 45, 44, 60, 61, 57, 56,
        42, 43, 47, 46, 62, 63, 59, 58,
        34, 35, 39, 38, 54, 55, 51, 50,
        32, 33, 37, 36, 52, 53, 49, 48
    };

    // packed {x, y, z} inside the tile -> serpentine index
    localparam logic [LOCAL_W-1:0] SERP_INDEX [64] = '{
         0,  1,  8,  9,  3,  2, 11, 10, 24, 25, 16, 17, 27, 26, 19, 18,
         7,  6, 15, 14,  4,  5, 12, 13, 31, 30, 23, 22, 28, 29, 20, 21,
        56, 57, 48, 49, 59, 58, 51, 50, 32, 33, 40, 41, 35, 34, 43, 42,
        63, 62, 55, 54, 60, 61, 52, 53, 39, 38, 47, 46, 36, 37, 44, 45
    };

endpackage

// ----- hdl/tlcc_in_if.sv -----
interface tlcc_in_if import tlcc_pkg::*; ();

    logic            valid;
    logic            ready;
    logic [ID_W-1:0] particle_id;

    modport source (output valid, output particle_id, input ready);
    modport sink   (input valid, input particle_id, output ready);

endinterface

// ----- hdl/tlcc_out_if.sv -----
interface tlcc_out_if import tlcc_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [CORNER_W-1:0] corner;
    logic [ID_W-1:0]     corner_id;
    logic                last_corner;

    modport source (output valid, output corner, output corner_id, output last_corner,
                    input ready);
    modport sink   (input valid, input corner, input corner_id, input last_corner,
                    output ready);

endinterface

// ----- hdl/tiled_lattice_cell_corner_ids_top.sv -----
// channel     | direction | handshake     | payload
// items       | in        | valid / ready | particle_id[29:0]
// results     | out       | valid / ready | corner[2:0], corner_id[29:0], last_corner
// apb config  | in        | psel/penable  | tile_side at byte address 0, pready tied high
//
// each of the three radix-8 dividers (tile -> x, y, z digits) takes a new particle
// only once its previous result is handed on, and the back end sends one corner
// per cycle while the output is not stalled, eight per particle
// reset clears all handshake state and sets tile_side to 1
// a stalled output holds the back end; the two-entry queue lets the dividers run on

module tiled_lattice_cell_corner_ids_top import tlcc_pkg::*;
#(
    parameter int MAX_TILE_SIDE = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    tlcc_in_if.sink            items,
    tlcc_out_if.source         results,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int SIDE_W  = $clog2(MAX_TILE_SIDE + 1);
    localparam int ENTRY_W = LOCAL_W + 3 * SIDE_W;

    logic [TILE_SIDE_W-1:0] tile_side_reg, tile_side_next;
    logic [SIDE_W-1:0]      side_reg, side_next;
    logic                   cfg_write;

    logic               q_in_valid, q_in_ready;
    logic [ENTRY_W-1:0] q_in_data;
    logic               q_out_valid, q_out_ready;
    logic [ENTRY_W-1:0] q_out_data;

    // register access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_TILE_SIDE);
    assign prdata    = (paddr[PADDR_W-1] == REG_TILE_SIDE) ? PDATA_W'(tile_side_reg) : '0;

    // effective side: zero acts as one, clamp at the maximum
    always_comb
    begin
        tile_side_next = pwdata[TILE_SIDE_W-1:0];
        priority if (tile_side_next == '0)
        begin
            side_next = SIDE_W'(1);
        end
        else if (32'(tile_side_next) > 32'(MAX_TILE_SIDE))
        begin
            side_next = SIDE_W'(MAX_TILE_SIDE);
        end
        else
        begin
            side_next = SIDE_W'(tile_side_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_side_reg <= TILE_SIDE_RESET;
            side_reg      <= SIDE_W'(1);
        end
        else if (cfg_write)
        begin
            tile_side_reg <= tile_side_next;
            side_reg      <= side_next;
        end
    end

    // front: split the id into tile digits
    tlcc_front #(.SIDE_W(SIDE_W)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .side    (side_reg),
        .items   (items),
        .q_valid (q_in_valid),
        .q_ready (q_in_ready),
        .q_data  (q_in_data)
    );

    // queue between front and back
    tlcc_fifo #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_in_valid),
        .push_ready (q_in_ready),
        .push_data  (q_in_data),
        .pop_valid  (q_out_valid),
        .pop_ready  (q_out_ready),
        .pop_data   (q_out_data)
    );

    // back: walk the eight corners
    tlcc_back #(.SIDE_W(SIDE_W)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .side       (side_reg),
        .head_valid (q_out_valid),
        .head_data  (q_out_data),
        .head_pop   (q_out_ready),
        .results    (results)
    );

endmodule

// ----- hdl/tlcc_div.sv -----
module tlcc_div import tlcc_pkg::*;
#(
    parameter int DIV_W = 9,
    parameter int SB_W  = 6
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [DIV_W-1:0]  divisor,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [TILE_W-1:0] in_dividend,
    input  logic [SB_W-1:0]   in_sb,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [TILE_W-1:0] out_quot,
    output logic [DIV_W-1:0]  out_rem,
    output logic [SB_W-1:0]   out_sb
);

    localparam int CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [TILE_W-1:0] quot_reg;
    logic [DIV_W-1:0]  rem_reg;
    logic [SB_W-1:0]   sb_reg;
    logic              load;
    logic [TILE_W-1:0] quot_v;
    logic [DIV_W-1:0]  rem_v;
    logic [DIV_W:0]    part_v;

    assign in_ready = !busy_reg && (!done_reg || out_ready);
    assign load     = in_valid && in_ready;

    // restoring division, DIV_BITS (three) quotient bits per cycle
    always_comb
    begin
        rem_v  = load ? '0 : rem_reg;
        quot_v = load ? in_dividend : quot_reg;
        part_v = '0;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            part_v = {rem_v, quot_v[TILE_W-1]};
            quot_v = {quot_v[TILE_W-2:0], 1'b0};
            if (part_v >= {1'b0, divisor})
            begin
                part_v    = part_v - {1'b0, divisor};
                quot_v[0] = 1'b1;
            end
            rem_v = part_v[DIV_W-1:0];
        end
    end

    // step counter and result hand-off
    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        if (load)
        begin
            cnt_next = CNT_W'(1);
            if (DIV_STEPS == 1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                busy_next = 1'b1;
                done_next = 1'b0;
            end
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (done_reg && out_ready)
        begin
            done_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (load || busy_reg)
        begin
            quot_reg <= quot_v;
            rem_reg  <= rem_v;
        end
        if (load)
        begin
            sb_reg <= in_sb;
        end
    end

    assign out_valid = done_reg;
    assign out_quot  = quot_reg;
    assign out_rem   = rem_reg;
    assign out_sb    = sb_reg;

    // a result is never shown while the division is still running
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        !(busy_reg && done_reg))
        else $error("divider shows a result while busy");

    // a loaded division is running or finished in the next cycle
    a_load_runs: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (busy_reg || done_reg))
        else $error("divider lost a transaction");

endmodule

// ----- hdl/tlcc_front.sv -----
module tlcc_front import tlcc_pkg::*;
#(
    parameter int SIDE_W = 9
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [SIDE_W-1:0]         side,
    tlcc_in_if.sink                   items,
    output logic                      q_valid,
    input  logic                      q_ready,
    output logic [LOCAL_W+3*SIDE_W-1:0] q_data
);

    logic              d1_valid, d1_ready;
    logic [TILE_W-1:0] d1_quot;
    logic [SIDE_W-1:0] d1_rem;
    logic [LOCAL_W-1:0] d1_sb;

    logic              d2_valid, d2_ready;
    logic [TILE_W-1:0] d2_quot;
    logic [SIDE_W-1:0] d2_rem;
    logic [LOCAL_W+SIDE_W-1:0] d2_sb;

    logic [SIDE_W-1:0] d3_rem;
    logic [LOCAL_W+2*SIDE_W-1:0] d3_sb;

    // tile number split into x digit and the rest
    tlcc_div #(.DIV_W(SIDE_W), .SB_W(LOCAL_W)) u_div_x (
        .clk         (clk),
        .rst_n       (rst_n),
        .divisor     (side),
        .in_valid    (items.valid),
        .in_ready    (items.ready),
        .in_dividend (items.particle_id[ID_W-1:LOCAL_W]),
        .in_sb       (items.particle_id[LOCAL_W-1:0]),
        .out_valid   (d1_valid),
        .out_ready   (d1_ready),
        .out_quot    (d1_quot),
        .out_rem     (d1_rem),
        .out_sb      (d1_sb)
    );

    // y digit and unbounded z tile
    tlcc_div #(.DIV_W(SIDE_W), .SB_W(LOCAL_W + SIDE_W)) u_div_y (
        .clk         (clk),
        .rst_n       (rst_n),
        .divisor     (side),
        .in_valid    (d1_valid),
        .in_ready    (d1_ready),
        .in_dividend (d1_quot),
        .in_sb       ({d1_sb, d1_rem}),
        .out_valid   (d2_valid),
        .out_ready   (d2_ready),
        .out_quot    (d2_quot),
        .out_rem     (d2_rem),
        .out_sb      (d2_sb)
    );

    // z tile wrapped into the cube
    tlcc_div #(.DIV_W(SIDE_W), .SB_W(LOCAL_W + 2 * SIDE_W)) u_div_z (
        .clk         (clk),
        .rst_n       (rst_n),
        .divisor     (side),
        .in_valid    (d2_valid),
        .in_ready    (d2_ready),
        .in_dividend (d2_quot),
        .in_sb       ({d2_sb, d2_rem}),
        .out_valid   (q_valid),
        .out_ready   (q_ready),
        .out_quot    (),
        .out_rem     (d3_rem),
        .out_sb      (d3_sb)
    );

    // queue entry: local index, tile x, tile y, tile z
    assign q_data = {d3_sb, d3_rem};

endmodule

// ----- hdl/tlcc_fifo.sv -----
module tlcc_fifo
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill count past its depth");

endmodule

// ----- hdl/tlcc_back.sv -----
module tlcc_back import tlcc_pkg::*;
#(
    parameter int SIDE_W = 9
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [SIDE_W-1:0]           side,
    input  logic                        head_valid,
    input  logic [LOCAL_W+3*SIDE_W-1:0] head_data,
    output logic                        head_pop,
    tlcc_out_if.source                  results
);

    localparam int ENTRY_W = LOCAL_W + 3 * SIDE_W;
    localparam int T_W     = 2 * SIDE_W;
    localparam int FLAT_W  = 3 * SIDE_W;

    // tile coordinate plus carry, wrapped at the cube edge
    function automatic logic [SIDE_W-1:0] wrap_inc(input logic [SIDE_W-1:0] v,
                                                   input logic carry,
                                                   input logic [SIDE_W-1:0] lim);
        logic [SIDE_W:0] s;
        s = {1'b0, v} + {{SIDE_W{1'b0}}, carry};
        return (s == {1'b0, lim}) ? '0 : s[SIDE_W-1:0];
    endfunction

    logic                en;
    logic [LOCAL_W-1:0]  h_local;
    logic [SIDE_W-1:0]   h_tx, h_ty, h_tz;
    logic [LOCAL_W-1:0]  h_pos;
    logic [2:0]          qx, qy, qz;

    logic [CORNER_W-1:0] corner_cnt_reg;
    logic                a_valid_reg;
    logic [CORNER_W-1:0] a_corner_reg;
    logic [SIDE_W-1:0]   a_cx_reg, a_cy_reg, a_cz_reg;
    logic [LOCAL_W-1:0]  a_lidx_reg;

    logic                b_valid_reg;
    logic [CORNER_W-1:0] b_corner_reg;
    logic [SIDE_W-1:0]   b_cx_reg;
    logic [LOCAL_W-1:0]  b_lidx_reg;
    logic [T_W-1:0]      b_t_reg;
    logic [T_W-1:0]      b_t_next;

    logic                out_valid_reg;
    logic [CORNER_W-1:0] out_corner_reg;
    logic [ID_W-1:0]     out_id_reg;
    logic [FLAT_W-1:0]   flat_next;

    // whole pipeline moves when the output register is free
    assign en       = !out_valid_reg || results.ready;
    assign head_pop = en && head_valid && (corner_cnt_reg == LAST_CORNER);

    // unpack the queue head and step to the current corner
    assign h_local = head_data[ENTRY_W-1 -: LOCAL_W];
    assign h_tx    = head_data[3*SIDE_W-1 -: SIDE_W];
    assign h_ty    = head_data[2*SIDE_W-1 -: SIDE_W];
    assign h_tz    = head_data[SIDE_W-1:0];
    assign h_pos   = SERP_POS[h_local];
    assign qx      = {1'b0, h_pos[5:4]} + {2'b00, corner_cnt_reg[2]};
    assign qy      = {1'b0, h_pos[3:2]} + {2'b00, corner_cnt_reg[1]};
    assign qz      = {1'b0, h_pos[1:0]} + {2'b00, corner_cnt_reg[0]};

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_cnt_reg <= '0;
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            if (head_valid)
            begin
                corner_cnt_reg <= corner_cnt_reg + CORNER_W'(1);
            end
            a_valid_reg   <= head_valid;
            b_valid_reg   <= a_valid_reg;
            out_valid_reg <= b_valid_reg;
        end
    end

    // stage a: corner tile coordinates and local index
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_corner_reg <= corner_cnt_reg;
            a_cx_reg     <= wrap_inc(h_tx, qx[2], side);
            a_cy_reg     <= wrap_inc(h_ty, qy[2], side);
            a_cz_reg     <= wrap_inc(h_tz, qz[2], side);
            a_lidx_reg   <= SERP_INDEX[{qx[1:0], qy[1:0], qz[1:0]}];
        end
    end

    // stage b: y + side * z
    assign b_t_next = T_W'(side) * T_W'(a_cz_reg) + T_W'(a_cy_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_corner_reg <= a_corner_reg;
            b_cx_reg     <= a_cx_reg;
            b_lidx_reg   <= a_lidx_reg;
            b_t_reg      <= b_t_next;
        end
    end

    // stage c: flat tile number and corner id into the output register
    assign flat_next = FLAT_W'(side) * FLAT_W'(b_t_reg) + FLAT_W'(b_cx_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_corner_reg <= b_corner_reg;
            out_id_reg     <= {TILE_W'(flat_next), b_lidx_reg};
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.corner      = out_corner_reg;
    assign results.corner_id   = out_id_reg;
    assign results.last_corner = (out_corner_reg == LAST_CORNER);

    // the queue head stays put while its corners are being walked
    a_head_held: assert property (@(posedge clk) disable iff (!rst_n)
        (corner_cnt_reg != '0) |-> head_valid)
        else $error("queue head lost in the middle of a corner walk");

endmodule
